// ===== hw/rtl/esp_pkg.sv =====
package esp_pkg;

   // widths fixed by the item and register layout
   localparam int FACTOR_W     = 24;
   localparam int SPEED_W      = 8;
   localparam int ADC_W        = 10;
   localparam int STAMP_FIELD_W = 16;
   localparam int DUTY_W       = 15;
   localparam int SUM_W        = 16;
   localparam int ERR_W        = SPEED_W + 2;
   localparam int PROD_W       = SPEED_W + ADC_W;
   localparam int DUTY_CALC_W  = SUM_W + 2;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = FACTOR_W;

   localparam int STAMP_BITS_DEF = 16;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET     = 24'd73242;
   localparam logic [SPEED_W-1:0]  CEILING_RESET    = 8'd150;
   localparam logic [SPEED_W-1:0]  FULL_SCALE_RESET = 8'd80;
   localparam logic [ADC_W-1:0]    ADC_FULL         = 10'd1023;
   localparam logic signed [DUTY_CALC_W-1:0] DUTY_MAX = 18'sd20000;
   localparam logic [DUTY_W-1:0]   DUTY_MAX_OUT     = 15'd20000;

   typedef enum logic [1:0] {
      KIND_CAPTURE = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_TARGET  = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SPEED_FACTOR      = 2'd0,
      REG_SPEED_CEILING     = 2'd1,
      REG_TARGET_FULL_SCALE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic capture;
      logic tgt_mul;
      logic tgt_fix;
      logic div_start;
      logic pi_sum;
      logic pi_duty;
   } cmd_type;

   typedef struct packed {
      logic period_zero;
      logic div_done;
      logic out_busy;
   } sts_type;

endpackage

// ===== hw/rtl/esp_div.sv =====
module esp_div import esp_pkg::*; #(
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [FACTOR_W-1:0]   dividend,
   input  logic [STAMP_BITS-1:0] divisor,
   output logic                  done,
   output logic [FACTOR_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(FACTOR_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FACTOR_W - 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FACTOR_W-1:0]   acc_ff, acc_in;
   logic [STAMP_BITS-1:0] rem_ff, rem_in;

   logic [STAMP_BITS:0]   trial;
   logic [STAMP_BITS:0]   diff;
   logic                  fits;

   // restoring division, one quotient bit per cycle shifted into the dividend register
   assign trial = {rem_ff, acc_ff[FACTOR_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = !diff[STAMP_BITS];
   assign done  = busy_ff && (cnt_ff == CNT_LAST);
   assign quotient = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[STAMP_BITS-1:0] : trial[STAMP_BITS-1:0];
         acc_in = {acc_ff[FACTOR_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done && !start |=> !busy_ff)
      else $error("divider still busy after last step");

endmodule

// ===== hw/rtl/esp_dp.sv =====
module esp_dp import esp_pkg::*; #(
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [STAMP_FIELD_W-1:0] stamp,
   input  logic [ADC_W-1:0]         adc,
   input  logic                     csr_valid,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DUTY_W-1:0]        rsp_duty,
   output logic [SPEED_W-1:0]       rsp_speed,
   output logic                     rsp_clamped
);

   logic [FACTOR_W-1:0]   factor_ff;
   logic [SPEED_W-1:0]    ceiling_ff;
   logic [SPEED_W-1:0]    full_scale_ff;

   logic [STAMP_BITS-1:0] last_stamp_ff;
   logic [STAMP_BITS-1:0] period_ff;
   logic [SPEED_W-1:0]    target_ff;
   logic signed [SUM_W-1:0] error_sum_ff;

   logic [PROD_W-1:0]     prod_ff;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic                  rsp_valid_ff;
   logic [DUTY_W-1:0]     rsp_duty_ff, rsp_duty_in;
   logic [SPEED_W-1:0]    rsp_speed_ff;
   logic                  rsp_clamped_ff, rsp_clamped_in;

   logic [STAMP_BITS-1:0] stamp_w;
   logic [FACTOR_W-1:0]   quotient;
   logic                  div_done;

   logic [SPEED_W-1:0]    q_est;
   logic [ADC_W:0]        q_rem;
   logic [SPEED_W-1:0]    target_in;

   logic [SUM_W:0]        sum_wide;
   logic signed [DUTY_CALC_W-1:0] err_x;
   logic signed [DUTY_CALC_W-1:0] duty;

   esp_div #(.STAMP_BITS(STAMP_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (factor_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign stamp_w = STAMP_BITS'(stamp);

   // x / 1023: estimate x >> 10, the leftover stays below 2 * 1023
   assign q_est = prod_ff[PROD_W-1:ADC_W];
   assign q_rem = {1'b0, prod_ff[ADC_W-1:0]} + {3'b000, q_est};
   assign target_in = (q_rem >= {1'b0, ADC_FULL}) ? q_est + 1'b1 : q_est;

   always_comb begin
      if (period_ff == '0) begin
         speed_in = ceiling_ff;
      end else if (quotient > {{(FACTOR_W-SPEED_W){1'b0}}, ceiling_ff}) begin
         speed_in = ceiling_ff;
      end else begin
         speed_in = quotient[SPEED_W-1:0];
      end
      err_in   = $signed({2'b00, target_ff}) - $signed({2'b00, speed_in});
      sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
                 + {{(SUM_W+1-ERR_W){err_in[ERR_W-1]}}, err_in};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      err_x = {{(DUTY_CALC_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
      duty  = (err_x <<< 3) + (err_x <<< 1)
              + {{(DUTY_CALC_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
      if (duty > DUTY_MAX) begin
         rsp_duty_in    = DUTY_MAX_OUT;
         rsp_clamped_in = 1'b1;
      end else if (duty[DUTY_CALC_W-1]) begin
         rsp_duty_in    = '0;
         rsp_clamped_in = 1'b1;
      end else begin
         rsp_duty_in    = duty[DUTY_W-1:0];
         rsp_clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff     <= FACTOR_RESET;
         ceiling_ff    <= CEILING_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SPEED_FACTOR:      factor_ff     <= csr_data;
            REG_SPEED_CEILING:     ceiling_ff    <= csr_data[SPEED_W-1:0];
            REG_TARGET_FULL_SCALE: full_scale_ff <= csr_data[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         period_ff     <= '0;
         target_ff     <= '0;
         error_sum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.capture) begin
            period_ff     <= stamp_w - last_stamp_ff;
            last_stamp_ff <= stamp_w;
         end
         if (cmd.tgt_fix) begin
            target_ff <= target_in;
         end
         if (cmd.pi_duty && !rsp_clamped_in) begin
            error_sum_ff <= sum_ff;
         end
         if (cmd.pi_duty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tgt_mul) begin
         prod_ff <= full_scale_ff * adc;
      end
      if (cmd.pi_sum) begin
         speed_ff <= speed_in;
         err_ff   <= err_in;
         sum_ff   <= sum_in;
      end
      if (cmd.pi_duty) begin
         rsp_duty_ff    <= rsp_duty_in;
         rsp_speed_ff   <= speed_ff;
         rsp_clamped_ff <= rsp_clamped_in;
      end
   end

   assign sts.period_zero = (period_ff == '0);
   assign sts.div_done    = div_done;
   assign sts.out_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_duty    = rsp_duty_ff;
   assign rsp_speed   = rsp_speed_ff;
   assign rsp_clamped = rsp_clamped_ff;

   a_rsp_from_duty: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.pi_duty))
      else $error("response raised without a duty step");

   a_clamp_holds_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.pi_duty && rsp_clamped_in |=> $stable(error_sum_ff))
      else $error("error sum moved on a clamped duty");

endmodule

// ===== hw/rtl/esp_ctrl.sv =====
module esp_ctrl import esp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_TARGET = 5'b00010,
      S_DIVIDE = 5'b00100,
      S_SUM    = 5'b01000,
      S_DUTY   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_CAPTURE: cmd.capture = 1'b1;
                  KIND_TARGET: begin
                     cmd.tgt_mul = 1'b1;
                     state_in    = S_TARGET;
                  end
                  KIND_TICK: begin
                     if (sts.period_zero) begin
                        state_in = S_SUM;
                     end else begin
                        cmd.div_start = 1'b1;
                        state_in      = S_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TARGET: begin
            cmd.tgt_fix = 1'b1;
            state_in    = S_IDLE;
         end
         S_DIVIDE: begin
            if (sts.div_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.pi_sum = 1'b1;
            state_in   = S_DUTY;
         end
         S_DUTY: begin
            // hold the result until the output register frees up
            if (!sts.out_busy) begin
               cmd.pi_duty = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_tick_divides: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_TICK) && !sts.period_zero
      |=> state_ff == S_DIVIDE)
      else $error("tick with a period did not start the divider");

   a_duty_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUTY) && sts.out_busy |=> state_ff == S_DUTY)
      else $error("duty step left while output was occupied");

endmodule

// ===== hw/rtl/encoder_speed_pi_controller.sv =====
// capture request: taken in idle; target request: multiply, then divide by 1023
// tick request: 24-step restoring divider for speed (skipped for a zero period), PI sum,
// then duty step (held while output busy); response valid and next request taken after it
// the response sits in an output register, so a new request is taken while it waits
// reset (synchronous, active high) restores the register defaults and clears period,
// last stamp, target speed, error sum and the response valid
module encoder_speed_pi_controller import esp_pkg::*; #(
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // capture_stamp[15:0], adc_value[25:16], zero
   input  logic [1:0]             req_tuser,  // kind[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // duty_scaled[14:0], measured_speed[22:15],
                                              // duty_clamped[23]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type              cmd;
   sts_type              sts;
   logic [DUTY_W-1:0]    rsp_duty;
   logic [SPEED_W-1:0]   rsp_speed;
   logic                 rsp_clamped;

   assign csr_ready = 1'b1;

   esp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   esp_dp #(.STAMP_BITS(STAMP_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .stamp       (req_tdata[STAMP_FIELD_W-1:0]),
      .adc         (req_tdata[STAMP_FIELD_W+ADC_W-1:STAMP_FIELD_W]),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_duty    (rsp_duty),
      .rsp_speed   (rsp_speed),
      .rsp_clamped (rsp_clamped)
   );

   assign rsp_tdata = {rsp_clamped, rsp_speed, rsp_duty};

endmodule
